[rtl/mprm_pkg.sv]
// Package for the multichannel peak rate meter: beat structs, slope state codes,
// fixed field widths and the rate format constants. No dependencies.
package mprm_pkg;

  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned SPM_W    = 32;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned DVD_W    = SPM_W + FRAC_W;
  localparam int unsigned RATE_W   = 24;
  localparam int unsigned STEP_W   = $clog2(DVD_W + 1);

  localparam logic [SPM_W-1:0]  SPM_RESET = 32'd60000;
  localparam logic [RATE_W-1:0] RATE_MAX  = '1;

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_RISE1 = 3'd1,
    ST_FALL1 = 3'd2,
    ST_RISE2 = 3'd3,
    ST_FALL0 = 3'd4
  } slope_e;

  typedef struct packed {
    logic [CHAN_W-1:0]       channel;
    logic signed [SMP_W-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_out;
    logic [RATE_W-1:0] beats_per_minute;
  } out_beat_t;

endpackage

[rtl/multichannel_peak_rate_meter_core.sv]
// Top level of the multichannel peak rate meter: record memory, slope update,
// divider. Depends on mprm_pkg, mprm_chan_ram, mprm_slope, mprm_div.
//
//  Channel | Direction | Handshake               | Beat
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | in_beat_i  (channel, sample)
//  out     | output    | out_valid_o/out_ready_i | out_beat_o (channel_out, bpm)
//  cfg     | input     | cfg_we_i (no wait)      | cfg_wdata_i (samples_per_minute)
//
// One sample beat per cycle unless a peak stalls the input. A beat's record is read
// from the memory at the edge that accepts it and written back at the edge that
// retires it from stage 1; a back-to-back beat on the same channel takes the record
// from the write-back forwarding register. A peak starts the one-bit-per-cycle
// divider at the edge that retires the peak beat; the divider runs its DVD_W (40)
// steps, then holds the rate on out until taken. The divider is free again the
// cycle after the rate is taken. A second peak while the divider is busy or its
// result is still unread stalls the input until the divider is free.
// Reset clears the per-channel valid bits; no clearing pass over the memory.
// Channel codes at or above CHANNELS are accepted and dropped.
module multichannel_peak_rate_meter_core #(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  mprm_pkg::in_beat_t         in_beat_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mprm_pkg::out_beat_t        out_beat_o,
  input  logic                       cfg_we_i,
  input  logic [mprm_pkg::SPM_W-1:0] cfg_wdata_i
);
  import mprm_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned REC_W = 3 + SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned EXT_W = 9;

  // samples per minute register
  logic [SPM_W-1:0] spm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spm_q <= SPM_RESET;
    end else if (cfg_we_i) begin
      spm_q <= cfg_wdata_i;
    end
  end

  // input side / memory read
  logic             accept;
  logic [EXT_W-1:0] in_ch_ext;
  logic             in_range;
  logic [IDX_W-1:0] rd_idx;

  assign accept    = in_valid_i & in_ready_o;
  assign in_ch_ext = EXT_W'(in_beat_i.channel);
  assign in_range  = in_ch_ext < EXT_W'(CHANNELS);
  assign rd_idx    = in_ch_ext[IDX_W-1:0];

  // stage 1: beat waiting for its record
  logic                   s1_valid_q;
  logic [CHAN_W-1:0]      s1_ch_q;
  logic [SAMPLE_BITS-1:0] s1_x_q;
  logic                   s1_vbit_q;
  logic [EXT_W-1:0]       s1_ch_ext;
  logic [IDX_W-1:0]       s1_idx;

  assign s1_ch_ext = EXT_W'(s1_ch_q);
  assign s1_idx    = s1_ch_ext[IDX_W-1:0];

  // per-entry valid bits stand in for the reset value of the memory
  logic [CHANNELS-1:0] ent_vld_q;

  // write-back forwarding: record written at the edge that read stage 1's entry
  logic             wb_vld_q;
  logic [IDX_W-1:0] wb_idx_q;
  logic [REC_W-1:0] wb_rec_q;

  logic [REC_W-1:0] ram_rdata;
  logic [REC_W-1:0] cur_rec, new_rec;

  always_comb begin
    if (wb_vld_q && (wb_idx_q == s1_idx)) begin
      cur_rec = wb_rec_q;
    end else if (s1_vbit_q) begin
      cur_rec = ram_rdata;
    end else begin
      cur_rec = {ST_START, {SAMPLE_BITS{1'b0}}, {COUNT_BITS{1'b0}}};
    end
  end

  slope_e                 cur_st, new_st;
  logic [SAMPLE_BITS-1:0] cur_prev, new_prev;
  logic [COUNT_BITS-1:0]  cur_cnt, new_cnt, div_cnt;
  logic                   emit;

  assign cur_st   = slope_e'(cur_rec[REC_W-1 -: 3]);
  assign cur_prev = cur_rec[COUNT_BITS +: SAMPLE_BITS];
  assign cur_cnt  = cur_rec[COUNT_BITS-1:0];
  assign new_rec  = {new_st, new_prev, new_cnt};

  mprm_slope #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_slope (
    .st_i     (cur_st),
    .prev_i   (cur_prev),
    .cnt_i    (cur_cnt),
    .x_i      (s1_x_q),
    .st_o     (new_st),
    .prev_o   (new_prev),
    .cnt_o    (new_cnt),
    .emit_o   (emit),
    .div_cnt_o(div_cnt)
  );

  // stage 1 retires unless a peak finds the divider occupied
  logic div_free, s1_fire;

  assign s1_fire    = s1_valid_q & (~emit | div_free);
  assign in_ready_o = ~s1_valid_q | s1_fire;

  mprm_chan_ram #(
    .DEPTH(CHANNELS),
    .WIDTH(REC_W),
    .IDX_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (s1_fire),
    .waddr_i(s1_idx),
    .wdata_i(new_rec),
    .re_i   (accept),
    .raddr_i(rd_idx),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wb_vld_q   <= 1'b0;
      ent_vld_q  <= '0;
    end else begin
      if (s1_fire) begin
        ent_vld_q[s1_idx] <= 1'b1;
      end
      if (accept) begin
        s1_valid_q <= in_range;
        s1_ch_q    <= in_beat_i.channel;
        s1_x_q     <= SAMPLE_BITS'(in_beat_i.sample);
        s1_vbit_q  <= ent_vld_q[rd_idx];
        // forward only the write that lands on the same edge as this read
        wb_vld_q   <= s1_fire;
        wb_idx_q   <= s1_idx;
        wb_rec_q   <= new_rec;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // rate = spm * 256 / count, saturated to 16.8
  mprm_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s1_fire & emit),
    .dividend_i ({spm_q, {FRAC_W{1'b0}}}),
    .divisor_i  (div_cnt),
    .channel_i  (s1_ch_q),
    .free_o     (div_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

endmodule

[rtl/mprm_chan_ram.sv]
// Per-channel record memory: one write port, one read port, registered read data.
// Depends on nothing.
module mprm_chan_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 51,
  parameter int unsigned IDX_W = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-address collision; caller forwards
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mprm_slope.sv]
// Slope machine update for one channel record: compare, count, peak detect.
// Depends on mprm_pkg.
module mprm_slope #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  mprm_pkg::slope_e         st_i,
  input  logic [SAMPLE_BITS-1:0]   prev_i,
  input  logic [COUNT_BITS-1:0]    cnt_i,
  input  logic [SAMPLE_BITS-1:0]   x_i,
  output mprm_pkg::slope_e         st_o,
  output logic [SAMPLE_BITS-1:0]   prev_o,
  output logic [COUNT_BITS-1:0]    cnt_o,
  output logic                     emit_o,
  output logic [COUNT_BITS-1:0]    div_cnt_o
);
  import mprm_pkg::*;

  logic                  lt, gt, change;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign lt      = $signed(x_i) < $signed(prev_i);
  assign gt      = $signed(x_i) > $signed(prev_i);
  assign cnt_inc = (cnt_i == '1) ? cnt_i : cnt_i + 1'b1;

  always_comb begin
    st_o   = st_i;
    cnt_o  = cnt_i;
    emit_o = 1'b0;
    change = 1'b0;
    unique case (st_i)
      ST_RISE1: begin
        if (lt) begin
          st_o   = ST_FALL1;
          cnt_o  = '0;
          change = 1'b1;
        end
      end
      ST_FALL1: begin
        cnt_o = cnt_inc;
        if (gt) begin
          st_o   = ST_RISE2;
          change = 1'b1;
        end
      end
      ST_RISE2: begin
        cnt_o = cnt_inc;
        if (lt) begin
          // new maximum: rate uses the incremented count, then restart
          st_o   = ST_FALL1;
          cnt_o  = '0;
          emit_o = 1'b1;
          change = 1'b1;
        end
      end
      ST_FALL0: begin
        if (gt) begin
          st_o   = ST_RISE1;
          change = 1'b1;
        end
      end
      default: begin
        // start, and any stray code; previous sample is never updated here
        change = 1'b1;
        if (lt) begin
          st_o = ST_FALL0;
        end else if (gt) begin
          st_o = ST_RISE1;
        end else begin
          st_o = ST_START;
        end
      end
    endcase
  end

  assign prev_o    = change ? prev_i : x_i;
  assign div_cnt_o = cnt_inc;

endmodule

[rtl/mprm_div.sv]
// Radix-2 restoring divider with saturation and result register.
// Depends on mprm_pkg.
module mprm_div #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mprm_pkg::DVD_W-1:0]  dividend_i,
  input  logic [COUNT_BITS-1:0]       divisor_i,
  input  logic [mprm_pkg::CHAN_W-1:0] channel_i,
  output logic                        free_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mprm_pkg::out_beat_t         out_beat_o
);
  import mprm_pkg::*;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_HOLD
  } div_state_e;

  div_state_e          state_q;
  logic [STEP_W-1:0]   step_q;
  logic [COUNT_BITS:0] rem_q;
  logic [DVD_W-1:0]    quo_q;
  logic [COUNT_BITS-1:0] dsr_q;
  logic [CHAN_W-1:0]   ch_q;
  logic [RATE_W-1:0]   rate_q;

  logic [COUNT_BITS:0] rem_sh, diff;
  logic                ge;
  logic [DVD_W-1:0]    quo_d;
  logic [COUNT_BITS:0] rem_d;

  assign rem_sh = {rem_q[COUNT_BITS-1:0], quo_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign rem_d  = ge ? diff : rem_sh;
  assign quo_d  = {quo_q[DVD_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        DV_IDLE: begin
          if (start_i) begin
            state_q <= DV_RUN;
            step_q  <= '0;
            rem_q   <= '0;
            quo_q   <= dividend_i;
            dsr_q   <= divisor_i;
            ch_q    <= channel_i;
          end
        end
        DV_RUN: begin
          rem_q  <= rem_d;
          quo_q  <= quo_d;
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(DVD_W - 1)) begin
            state_q <= DV_HOLD;
            rate_q  <= (quo_d[DVD_W-1:RATE_W] != '0) ? RATE_MAX : quo_d[RATE_W-1:0];
          end
        end
        DV_HOLD: begin
          if (out_ready_i) begin
            state_q <= DV_IDLE;
          end
        end
        default: begin
          state_q <= DV_IDLE;
        end
      endcase
    end
  end

  assign free_o      = (state_q == DV_IDLE);
  assign out_valid_o = (state_q == DV_HOLD);
  assign out_beat_o  = '{channel_out: ch_q, beats_per_minute: rate_q};

endmodule

[verif/multichannel_peak_rate_meter_core_test.sv]
// Self-checking testbench for multichannel_peak_rate_meter_core: per-channel slope
// tracking and rate prediction in a small scoreboard class, with random sender
// bursts and receiver stalls. Depends on mprm_pkg and the core RTL.
module multichannel_peak_rate_meter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mprm_pkg::*;

  localparam int unsigned N_CH         = 8;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned PHASE_ITEMS  = 284;
  localparam int unsigned DRAIN_CYCLES = 64;    // divider pass plus hold and write-back
  localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_MOSTLY
  } rx_mode_e;

  // Tracks each channel's slope machine and queues the rate each peak must yield.
  class rate_scoreboard;
    logic [SPM_W-1:0]        rate_base             = SPM_RESET;
    slope_e                  slope[N_CH]           = '{default: ST_START};
    logic signed [SMP_W-1:0] prev_smp[N_CH]        = '{default: '0};
    logic [CNT_W-1:0]        peak_gap[N_CH]        = '{default: '0};
    out_beat_t               rates_due[$];
    int unsigned             errors                = 0;

    function void note_sample(in_beat_t b);
      int unsigned             ch;
      logic signed [SMP_W-1:0] x;
      logic signed [SMP_W-1:0] p;
      logic                    moved;
      logic                    peak;
      logic [DVD_W-1:0]        quot;
      out_beat_t               r;
      ch    = b.channel;
      if (ch >= N_CH) return;
      x     = b.sample;
      p     = prev_smp[ch];
      moved = 1'b0;
      peak  = 1'b0;
      case (slope[ch])
        ST_RISE1: begin
          if (x < p) begin
            slope[ch]    = ST_FALL1;
            peak_gap[ch] = '0;
            moved        = 1'b1;
          end
        end
        ST_FALL1: begin
          if (!(&peak_gap[ch])) peak_gap[ch] = peak_gap[ch] + 1'b1;
          if (x > p) begin
            slope[ch] = ST_RISE2;
            moved     = 1'b1;
          end
        end
        ST_RISE2: begin
          if (!(&peak_gap[ch])) peak_gap[ch] = peak_gap[ch] + 1'b1;
          if (x < p) begin
            slope[ch] = ST_FALL1;
            peak      = 1'b1;
            moved     = 1'b1;
          end
        end
        ST_FALL0: begin
          if (x > p) begin
            slope[ch] = ST_RISE1;
            moved     = 1'b1;
          end
        end
        default: begin
          // start state never takes the sample as its reference
          if (x < p) slope[ch] = ST_FALL0;
          else if (x > p) slope[ch] = ST_RISE1;
          else slope[ch] = ST_START;
          moved = 1'b1;
        end
      endcase
      if (!moved) prev_smp[ch] = x;
      if (peak) begin
        if (peak_gap[ch] == '0) quot = '0;
        else quot = {rate_base, {FRAC_W{1'b0}}} / peak_gap[ch];
        r.channel_out      = ch[CHAN_W-1:0];
        r.beats_per_minute = (quot > RATE_MAX) ? RATE_MAX : quot[RATE_W-1:0];
        rates_due.push_back(r);
        peak_gap[ch] = '0;
      end
    endfunction

    function void check_rate(out_beat_t got);
      out_beat_t want;
      if (rates_due.size() == 0) begin
        $error("unexpected rate beat: channel_out %0d beats_per_minute %0d",
               got.channel_out, got.beats_per_minute);
        errors++;
        return;
      end
      want = rates_due.pop_front();
      if (got.channel_out !== want.channel_out) begin
        $error("channel_out: expected %0d, got %0d", want.channel_out, got.channel_out);
        errors++;
      end
      if (got.beats_per_minute !== want.beats_per_minute) begin
        $error("beats_per_minute: expected %0d, got %0d",
               want.beats_per_minute, got.beats_per_minute);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_beat_t         in_beat_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_beat_t        out_beat_o;
  logic             cfg_we_i    = 1'b0;
  logic [SPM_W-1:0] cfg_wdata_i = '0;

  rate_scoreboard rate_sb = new;
  bit             hold_req = 1'b0;
  int unsigned    cycles = 0;

  // per-channel waveform generator state
  int                      wave_lvl[N_CH]  = '{default: 0};
  bit                      wave_up[N_CH]   = '{default: 1'b0};
  int                      wave_left[N_CH] = '{default: 0};
  int                      wave_step[N_CH] = '{default: 1};
  logic signed [SMP_W-1:0] last_sent[N_CH] = '{default: '0};

  multichannel_peak_rate_meter_core #(
    .CHANNELS    (N_CH),
    .SAMPLE_BITS (SMP_W),
    .COUNT_BITS  (CNT_W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output beats are sampled with pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) rate_sb.check_rate(out_beat_o);
  end

  // Receiver: stall pattern switches at random intervals; one long hold-off on request.
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned left;
    mode = RX_OPEN;
    left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(RX_OPEN, RX_MOSTLY));
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= ($urandom_range(0, 1) == 1);
        RX_EVERY4: out_ready_i <= (left % 4 == 0);
        default:   out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_beat(input logic [CHAN_W-1:0] ch, input logic signed [SMP_W-1:0] smp);
    in_beat_t b;
    b.channel = ch;
    b.sample  = smp;
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rate_sb.note_sample(b);
    last_sent[ch] = smp;
  endtask

  task automatic idle_sender(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_rates_drained();
    in_valid_i <= 1'b0;
    while (rate_sb.rates_due.size() != 0) @(posedge clk_i);
  endtask

  // Register writes only with the block idle: all rates out and the divider settled.
  task automatic write_rate_base(input logic [SPM_W-1:0] v);
    wait_rates_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate_sb.rate_base = v;
  endtask

  // Mostly ramp waveforms so every channel walks through its peaks; some
  // flat repeats and full-range noise mixed in.
  task automatic run_samples(input int unsigned n, input bit long_hold, input bit mid_pause);
    int unsigned             sent;
    int unsigned             burst;
    int unsigned             kind;
    logic [CHAN_W-1:0]       ch;
    logic signed [SMP_W-1:0] smp;
    int                      lvl;
    sent = 0;
    ch   = '0;
    if (long_hold) hold_req = 1'b1;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && sent < n) begin
        if ($urandom_range(0, 9) >= 3) ch = CHAN_W'($urandom_range(0, N_CH - 1));
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
          smp = SMP_W'($urandom_range(0, 65535));
        end else if (kind < 22) begin
          smp = last_sent[ch];
        end else begin
          if (wave_left[ch] == 0) begin
            wave_up[ch]   = !wave_up[ch];
            wave_left[ch] = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(1, 6);
            wave_step[ch] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20000)
                                                         : $urandom_range(1, 600);
          end
          wave_left[ch]--;
          lvl = wave_lvl[ch] + (wave_up[ch] ? wave_step[ch] : -wave_step[ch]);
          if (lvl > 32767) lvl = 32767;
          if (lvl < -32768) lvl = -32768;
          wave_lvl[ch] = lvl;
          smp = lvl[SMP_W-1:0];
        end
        send_beat(ch, smp);
        sent++;
        burst--;
        if (mid_pause && sent == n / 2) wait_rates_drained();
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  initial begin : stimulus
    logic [SPM_W-1:0] phase_rate[6];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset rate: flat start, extremes, equal samples and beats back to back
    // on one channel.
    send_beat(3'd0, 16'sd0);
    send_beat(3'd0, 16'sd100);
    send_beat(3'd0, 16'sd200);
    send_beat(3'd0, 16'sh7FFF);
    send_beat(3'd0, -16'sh8000);
    send_beat(3'd0, -16'sh8000);
    send_beat(3'd0, -16'sh8000);
    send_beat(3'd0, 16'sh7FFF);
    send_beat(3'd0, 16'sh7FFF);
    send_beat(3'd0, 16'sd5);
    send_beat(3'd7, -16'sh8000);
    send_beat(3'd7, -16'sd40);
    send_beat(3'd7, 16'sd10);
    send_beat(3'd7, 16'sd9);
    send_beat(3'd7, 16'sd11);
    send_beat(3'd7, 16'sd10);
    send_beat(3'd7, 16'sd12);
    send_beat(3'd7, 16'sd11);
    send_beat(3'd3, 16'sd1);
    send_beat(3'd3, -16'sd1);
    send_beat(3'd3, 16'sd2);
    send_beat(3'd3, 16'sd3);
    send_beat(3'd7, 16'sd20);
    send_beat(3'd3, -16'sd3);
    send_beat(3'd7, 16'sd19);

    // Rate base per phase: extremes first, then zero, random and ordinary values.
    phase_rate[0] = 32'hFFFF_FFFF;
    phase_rate[1] = 32'd1;
    phase_rate[2] = 32'd0;
    phase_rate[3] = $urandom();
    phase_rate[4] = 32'd60000;
    phase_rate[5] = $urandom_range(1, 5000);
    for (int i = 0; i < 6; i++) begin
      write_rate_base(phase_rate[i]);
      run_samples(PHASE_ITEMS, i == 1, i == 3);
    end

    wait_rates_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (rate_sb.errors == 0 && rate_sb.rates_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[multichannel_peak_rate_meter_core.f]
rtl/mprm_pkg.sv
rtl/mprm_chan_ram.sv
rtl/mprm_slope.sv
rtl/mprm_div.sv
rtl/multichannel_peak_rate_meter_core.sv
verif/multichannel_peak_rate_meter_core_test.sv
